>>> hw/rtl/clcd_pkg.sv
// shared types and constants for the character lcd nibble write queue
// no dependencies; used by clcd_queue, clcd_engine and the top level
package clcd_pkg;

  // defaults
  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam logic [7:0]  STARTUP_RESET   = 8'd50;
  localparam logic [7:0]  NIBBLES_PER_BYTE = 8'd2;

  // input operation codes
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // input beat payload
  typedef struct packed {
    logic       op;
    logic       is_cmd;
    logic [7:0] byte_value;
  } in_item_t;

  // result beat payload
  typedef struct packed {
    logic       accepted;
    logic       rs_level;
    logic       enable_level;
    logic [3:0] data_nibble;
    logic       queue_empty;
  } out_item_t;

  // one queued byte
  typedef struct packed {
    logic       is_cmd;
    logic [7:0] value;
  } entry_t;

  // queue status seen by the engine and the top level
  typedef struct packed {
    logic   empty;
    logic   full;
    logic   empty_nxt;
    entry_t head;
  } q_stat_t;

  // lcd pin levels
  typedef struct packed {
    logic       rs;
    logic       e;
    logic [3:0] nibble;
  } pins_t;

endpackage

>>> hw/rtl/char_lcd_nibble_write_queue_top.sv
// top level of the character lcd nibble write queue
// depends on clcd_pkg, clcd_queue and clcd_engine
//
// usage:
//   in channel (in_valid/in_stall/in_item): each beat is either an enqueue of
//   a command or data byte, or one timer tick that advances the lcd engine.
//   out channel (out_valid/out_stall/out_item): exactly one result beat per
//   input beat, with the enqueue status, the RS, E and DB7..DB4 pin levels
//   and the queue empty flag after the step.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes startup_ticks; always
//   ready. Written during the start-up wait it restarts the wait.
// timing and throughput:
//   a result is taken into the output register in the cycle after its input beat;
//   one beat per cycle while the receiver does not stall, set by the single queue
//   write port and the registered head read that always tracks the oldest entry.
// reset:
//   pointers clear, pins go low, the engine enters the start-up wait with the
//   default count of 50 ticks. Queue storage is not cleared.
// stall:
//   in_stall is raised while a result waits in the output register and the
//   receiver stalls; the result holds until taken.
module char_lcd_nibble_write_queue_top #(
  parameter int unsigned QUEUE_DEPTH = clcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  clcd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output clcd_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  logic                in_beat, push, tick, pop;
  logic                out_valid_r;
  clcd_pkg::out_item_t out_item_r;
  clcd_pkg::entry_t    push_entry;
  clcd_pkg::q_stat_t   stat;
  clcd_pkg::pins_t     pins_nxt;

  // handshake
  assign in_stall  = out_valid_r & out_stall;
  assign in_beat   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign push      = in_beat && (in_item.op == clcd_pkg::OP_ENQUEUE) && !stat.full;
  assign tick      = in_beat && (in_item.op == clcd_pkg::OP_TICK);

  assign push_entry.is_cmd = in_item.is_cmd;
  assign push_entry.value  = in_item.byte_value;

  clcd_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .stat      (stat)
  );

  clcd_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick     (tick),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_value(cfg_data),
    .stat     (stat),
    .pop      (pop),
    .pins_nxt (pins_nxt)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_beat | (out_valid_r & out_stall);
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      out_item_r.accepted     <= push;
      out_item_r.rs_level     <= pins_nxt.rs;
      out_item_r.enable_level <= pins_nxt.e;
      out_item_r.data_nibble  <= pins_nxt.nibble;
      out_item_r.queue_empty  <= stat.empty_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> hw/rtl/clcd_queue.sv
// ring queue of command or data bytes with a registered head read
// depends on clcd_pkg (entry_t, q_stat_t)
module clcd_queue #(
  parameter int unsigned QUEUE_DEPTH = clcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  clcd_pkg::entry_t  push_entry,
  input  logic              pop,
  output clcd_pkg::q_stat_t stat
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

  clcd_pkg::entry_t mem [QUEUE_DEPTH];
  clcd_pkg::entry_t head_r;

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_inc;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt, rd_ptr_inc;

  // pointer advance with wrap at the queue depth
  assign wr_ptr_inc = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + AW'(1);
  assign rd_ptr_inc = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + AW'(1);
  assign wr_ptr_nxt = push ? wr_ptr_inc : wr_ptr_r;
  assign rd_ptr_nxt = pop  ? rd_ptr_inc : rd_ptr_r;

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // storage; head register tracks the entry at the next read pointer,
  // forwarding a write that lands on that slot in the same cycle
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= push_entry;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  // status, one slot always stays free
  assign stat.empty     = (wr_ptr_r == rd_ptr_r);
  assign stat.full      = (wr_ptr_inc == rd_ptr_r);
  assign stat.empty_nxt = (wr_ptr_nxt == rd_ptr_nxt);
  assign stat.head      = head_r;

endmodule

>>> hw/rtl/clcd_engine.sv
// hd44780 style 4-bit write sequencer: start-up wait, then two nibbles per byte
// depends on clcd_pkg (q_stat_t, pins_t, constants)
module clcd_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_value,
  input  clcd_pkg::q_stat_t stat,
  output logic              pop,
  output clcd_pkg::pins_t   pins_nxt
);

  localparam logic [2:0] PH_WAIT   = 3'd0;
  localparam logic [2:0] PH_IDLE   = 3'd1;
  localparam logic [2:0] PH_E_HIGH = 3'd2;
  localparam logic [2:0] PH_E_LOW  = 3'd3;
  localparam logic [2:0] PH_NEXT   = 3'd4;

  logic [2:0]      phase_r, phase_nxt;
  logic [7:0]      cnt_r, cnt_nxt, cnt_dec;
  logic [7:0]      startup_r, startup_nxt;
  clcd_pkg::pins_t pins_r;

  assign cnt_dec = cnt_r - 8'd1;

  // phase sequencing on each tick, register write reloads the wait
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    startup_nxt = startup_r;
    pins_nxt    = pins_r;
    pop         = 1'b0;
    if (tick) begin
      unique case (phase_r)
        PH_WAIT: begin
          cnt_nxt = cnt_dec;
          if (cnt_dec == 8'd0) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_IDLE: begin
          if (!stat.empty) begin
            pins_nxt.rs     = ~stat.head.is_cmd;
            pins_nxt.nibble = stat.head.value[7:4];
            cnt_nxt         = clcd_pkg::NIBBLES_PER_BYTE;
            phase_nxt       = PH_E_HIGH;
          end
        end
        PH_E_HIGH: begin
          pins_nxt.e = 1'b1;
          phase_nxt  = PH_E_LOW;
        end
        PH_E_LOW: begin
          pins_nxt.e = 1'b0;
          phase_nxt  = PH_NEXT;
        end
        PH_NEXT: begin
          cnt_nxt = cnt_dec;
          if (cnt_dec != 8'd0) begin
            pins_nxt.nibble = stat.head.value[3:0];
            phase_nxt       = PH_E_HIGH;
          end else begin
            pop       = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    if (cfg_we) begin
      startup_nxt = cfg_value;
      if (phase_r == PH_WAIT) begin
        cnt_nxt = cfg_value;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      cnt_r     <= clcd_pkg::STARTUP_RESET;
      startup_r <= clcd_pkg::STARTUP_RESET;
      pins_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      startup_r <= startup_nxt;
      pins_r    <= pins_nxt;
    end
  end

endmodule

>>> sim/char_lcd_nibble_write_queue_top_tb.sv
// self-checking testbench for char_lcd_nibble_write_queue_top: predicts every result beat
// from its own model of the start-up wait, the ring queue and the nibble engine
// depends on clcd_pkg and char_lcd_nibble_write_queue_top
module char_lcd_nibble_write_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH      = clcd_pkg::QUEUE_DEPTH_DEF;
  localparam int unsigned PTR_W       = $clog2(QDEPTH);
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned IDLE_PCT    = 6;

  typedef enum logic [2:0] {
    ENG_WAIT, ENG_IDLE, ENG_E_HIGH, ENG_E_LOW, ENG_NEXT
  } eng_phase_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  clcd_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  clcd_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_data  = '0;

  // model of the block
  logic [7:0]       start_ticks = clcd_pkg::STARTUP_RESET;
  logic             q_kind [QDEPTH];
  logic [7:0]       q_byte [QDEPTH];
  logic [PTR_W-1:0] wr_ptr = '0;
  logic [PTR_W-1:0] rd_ptr = '0;
  eng_phase_t       eng    = ENG_WAIT;
  logic [7:0]       cnt    = clcd_pkg::STARTUP_RESET;
  logic             pin_rs = 1'b0;
  logic             pin_e  = 1'b0;
  logic [3:0]       pin_nib = '0;

  clcd_pkg::in_item_t  beats_pending [$];
  clcd_pkg::out_item_t pins_due [$];
  clcd_pkg::out_item_t pins_want;
  int        errors = 0;
  int        cycles = 0;
  bit        calm   = 1'b0;

  char_lcd_nibble_write_queue_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one step of the model (an enqueue or an lcd engine tick), returns the result beat after the step
  function automatic clcd_pkg::out_item_t lcd_step(input clcd_pkg::in_item_t it);
    clcd_pkg::out_item_t r;
    r = '0;
    if (it.op == clcd_pkg::OP_ENQUEUE) begin
      if (wr_ptr + PTR_W'(1) != rd_ptr) begin
        q_kind[wr_ptr] = it.is_cmd;
        q_byte[wr_ptr] = it.byte_value;
        wr_ptr = wr_ptr + PTR_W'(1);
        r.accepted = 1'b1;
      end
    end else begin
      case (eng)
        ENG_WAIT: begin
          cnt = cnt - 8'd1;
          if (cnt == 8'd0) eng = ENG_IDLE;
        end
        ENG_IDLE: begin
          if (wr_ptr != rd_ptr) begin
            pin_rs  = ~q_kind[rd_ptr];
            pin_nib = q_byte[rd_ptr][7:4];
            cnt     = clcd_pkg::NIBBLES_PER_BYTE;
            eng     = ENG_E_HIGH;
          end
        end
        ENG_E_HIGH: begin
          pin_e = 1'b1;
          eng   = ENG_E_LOW;
        end
        ENG_E_LOW: begin
          pin_e = 1'b0;
          eng   = ENG_NEXT;
        end
        ENG_NEXT: begin
          cnt = cnt - 8'd1;
          if (cnt != 8'd0) begin
            pin_nib = q_byte[rd_ptr][3:0];
            eng     = ENG_E_HIGH;
          end else begin
            rd_ptr = rd_ptr + PTR_W'(1);
            eng    = ENG_IDLE;
          end
        end
        default: eng = ENG_IDLE;
      endcase
    end
    r.rs_level     = pin_rs;
    r.enable_level = pin_e;
    r.data_nibble  = pin_nib;
    r.queue_empty  = (wr_ptr == rd_ptr);
    return r;
  endfunction

  // random beat, tick_pct percent of them ticks
  function automatic clcd_pkg::in_item_t rand_beat(input int unsigned tick_pct);
    clcd_pkg::in_item_t b;
    b.op         = ($urandom_range(99) < tick_pct) ? clcd_pkg::OP_TICK : clcd_pkg::OP_ENQUEUE;
    b.is_cmd     = 1'($urandom_range(1));
    b.byte_value = 8'($urandom_range(255));
    return b;
  endfunction

  task automatic push_beat(input logic op, input logic kind, input logic [7:0] val);
    clcd_pkg::in_item_t b;
    b.op         = op;
    b.is_cmd     = kind;
    b.byte_value = val;
    beats_pending.push_back(b);
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // wait until every beat is sent and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (beats_pending.size() != 0 || in_valid || pins_due.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // startup_ticks write, only while the block is idle
  task automatic write_startup(input logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    start_ticks = v;
    if (eng == ENG_WAIT) cnt = start_ticks;
    @(negedge clk);
  endtask

  // input driver: accepted beats go through the model
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) pins_due.push_back(lcd_step(in_item));
      if (!in_valid || !in_stall) begin
        if (beats_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_item  <= beats_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pins_due.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing due: %p", out_item));
        end else begin
          pins_want = pins_due.pop_front();
          if (out_item.accepted !== pins_want.accepted)
            report_mismatch($sformatf("accepted %b, want %b",
                            out_item.accepted, pins_want.accepted));
          if (out_item.rs_level !== pins_want.rs_level)
            report_mismatch($sformatf("rs_level %b, want %b",
                            out_item.rs_level, pins_want.rs_level));
          if (out_item.enable_level !== pins_want.enable_level)
            report_mismatch($sformatf("enable_level %b, want %b",
                            out_item.enable_level, pins_want.enable_level));
          if (out_item.data_nibble !== pins_want.data_nibble)
            report_mismatch($sformatf("data_nibble %h, want %h",
                            out_item.data_nibble, pins_want.data_nibble));
          if (out_item.queue_empty !== pins_want.queue_empty)
            report_mismatch($sformatf("queue_empty %b, want %b",
                            out_item.queue_empty, pins_want.queue_empty));
        end
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    int unsigned        ticks_sent;
    clcd_pkg::in_item_t b;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // field extremes during the default start-up wait, ticks carry junk fields
    push_beat(clcd_pkg::OP_ENQUEUE, 1'b1, 8'hff);
    push_beat(clcd_pkg::OP_ENQUEUE, 1'b0, 8'h00);
    push_beat(clcd_pkg::OP_ENQUEUE, 1'b1, 8'h5a);
    push_beat(clcd_pkg::OP_ENQUEUE, 1'b0, 8'ha5);
    push_beat(clcd_pkg::OP_TICK, 1'b1, 8'hff);
    push_beat(clcd_pkg::OP_TICK, 1'b0, 8'h00);
    push_beat(clcd_pkg::OP_TICK, 1'b0, 8'h3c);
    wait_drained();

    // write during the wait restarts it
    write_startup(8'hff);
    push_beat(clcd_pkg::OP_TICK, 1'b0, 8'h00);
    push_beat(clcd_pkg::OP_TICK, 1'b1, 8'hff);
    push_beat(clcd_pkg::OP_ENQUEUE, 1'b1, 8'h0f);
    push_beat(clcd_pkg::OP_ENQUEUE, 1'b0, 8'hf0);
    wait_drained();

    // zero count wraps to a 256 tick wait, mostly ticks until it ends
    write_startup(8'h00);
    ticks_sent = 0;
    while (ticks_sent < 262) begin
      b = rand_beat(95);
      if (b.op == clcd_pkg::OP_TICK) ticks_sent++;
      beats_pending.push_back(b);
    end
    wait_drained();

    // after the wait a write only changes the register; drain with no idling
    write_startup(8'h01);
    calm = 1'b1;
    repeat (250) beats_pending.push_back(rand_beat(97));
    wait_drained();
    calm = 1'b0;

    // enqueue burst runs into a full queue
    repeat (80) beats_pending.push_back(rand_beat(0));
    wait_drained();

    write_startup(8'hff);
    repeat (150) beats_pending.push_back(rand_beat(75));
    wait_drained();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> char_lcd_nibble_write_queue_top.f
hw/rtl/clcd_pkg.sv
hw/rtl/clcd_queue.sv
hw/rtl/clcd_engine.sv
hw/rtl/char_lcd_nibble_write_queue_top.sv
sim/char_lcd_nibble_write_queue_top_tb.sv
